FILE: hdl/rmv_pkg.sv
package rmv_pkg;

   localparam int COUNT_BITS_DEFAULT = 24;
   localparam int FRAC_BITS_DEFAULT  = 16;

   localparam int KIND_W      = 2;
   localparam int SAMPLE_W    = 16;
   localparam int SAMPLE_FRAC = 8;
   localparam int MEAN_W      = 32;
   localparam int STD_W       = 32;
   localparam int CNT_OUT_W   = 24;
   localparam int SUM_W       = 64;
   localparam int MAG_W       = 32;
   localparam int HALF_W      = MAG_W / 2;
   localparam int PP_W        = MAG_W + HALF_W;
   localparam int ROOT_W      = SUM_W / 2;
   localparam int STEP_W      = $clog2(SUM_W + 1);

   // request kinds; the top code is not decoded and is dropped
   typedef enum logic [KIND_W-1:0] {
      KIND_ADD    = 2'd0,
      KIND_CLEAR  = 2'd1,
      KIND_REPORT = 2'd2,
      KIND_NONE   = 2'd3
   } req_kind_type;

   // deviation source for the response register
   typedef enum logic [1:0] {
      DEV_ZERO = 2'd0,
      DEV_ONES = 2'd1,
      DEV_ROOT = 2'd2
   } dev_sel_type;

   typedef struct packed {
      logic        capture;
      logic        clear;
      logic        delta;
      logic        div_start;
      logic        div_report;
      logic        mean_upd;
      logic        err;
      logic        mul_lo;
      logic        mul_hi;
      logic        prod;
      logic        acc;
      logic        sqrt_start;
      logic        rsp_load;
      dev_sel_type dev_sel;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic sqrt_done;
      logic few_samples;
      logic dev_overflow;
   } status_type;

endpackage

FILE: hdl/rmv_div.sv
module rmv_div
   import rmv_pkg::*;
#(
   parameter int DIVISOR_W = COUNT_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SUM_W-1:0]     dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   input  logic [STEP_W-1:0]    steps,
   output logic                 done,
   output logic [SUM_W-1:0]     quotient
);

   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] div_ff;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [STEP_W-1:0]    left_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIVISOR_W:0]   trial;
   logic                 fits;

   // one quotient bit per cycle, dividend bits shift out of the top of quo_ff
   always_comb begin
      trial  = {rem_ff, quo_ff[SUM_W-1]};
      fits   = (trial >= {1'b0, div_ff});
      rem_in = fits ? DIVISOR_W'(trial - {1'b0, div_ff}) : trial[DIVISOR_W-1:0];
      quo_in = {quo_ff[SUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            left_ff <= steps;
         end else if (busy_ff) begin
            left_ff <= left_ff - STEP_W'(1);
            if (left_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hdl/rmv_sqrt.sv
module rmv_sqrt
   import rmv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [SUM_W-1:0]    rad_ff;
   logic [ROOT_W+1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0]    left_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [ROOT_W+1:0]   rem_try;
   logic [ROOT_W+1:0]   sub_try;

   // one root bit per cycle from the top two radicand bits
   always_comb begin
      rem_try = {rem_ff[ROOT_W-1:0], rad_ff[SUM_W-1 -: 2]};
      sub_try = {root_ff, 2'b01};
      if (rem_try >= sub_try) begin
         rem_in  = rem_try - sub_try;
         root_in = {root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_try;
         root_in = {root_ff[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            left_ff <= CNT_W'(ROOT_W);
         end else if (busy_ff) begin
            left_ff <= left_ff - CNT_W'(1);
            if (left_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[SUM_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: hdl/rmv_datapath.sv
module rmv_datapath
   import rmv_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic signed [MEAN_W-1:0]   rsp_mean,
   output logic [STD_W-1:0]           rsp_std_dev,
   output logic [CNT_OUT_W-1:0]       rsp_sample_count,
   output logic                       rsp_valid_res,
   output logic                       rsp_saturated
);

   logic [COUNT_BITS-1:0]     count_ff;
   logic signed [MEAN_W-1:0]  mean_ff;
   logic [SUM_W-1:0]          m2_ff;
   logic                      sat_ff;

   logic signed [MEAN_W-1:0]  x_ff;
   logic [MAG_W-1:0]          dmag_ff;
   logic                      dneg_ff;
   logic [MAG_W-1:0]          emag_ff;
   logic [PP_W-1:0]           pp_lo_ff;
   logic [PP_W-1:0]           pp_hi_ff;
   logic [SUM_W-1:0]          prod_ff;

   logic signed [MEAN_W-1:0]  x_in;
   logic signed [MEAN_W:0]    delta_in;
   logic signed [MEAN_W:0]    e_in;
   logic [MAG_W-1:0]          step_q;
   logic [HALF_W-1:0]         mul_op;
   logic [PP_W-1:0]           pp_in;
   logic [SUM_W-1:0]          prod_full;
   logic [SUM_W:0]            sum_in;

   logic [SUM_W-1:0]          div_dividend;
   logic [COUNT_BITS-1:0]     div_divisor;
   logic [STEP_W-1:0]         div_steps;
   logic                      div_done;
   logic [SUM_W-1:0]          quotient;
   logic                      sqrt_done;
   logic [ROOT_W-1:0]         root;

   logic signed [MEAN_W-1:0]  rsp_mean_ff;
   logic [STD_W-1:0]          rsp_std_ff;
   logic [CNT_OUT_W-1:0]      rsp_count_ff;
   logic                      rsp_valid_res_ff;
   logic                      rsp_sat_ff;
   logic                      few_samples;

   always_comb begin
      x_in      = MEAN_W'(req_sample) <<< (FRAC_BITS - SAMPLE_FRAC);
      delta_in  = (MEAN_W + 1)'(x_ff) - (MEAN_W + 1)'(mean_ff);
      e_in      = (MEAN_W + 1)'(x_ff) - (MEAN_W + 1)'(mean_ff);
      step_q    = quotient[MAG_W-1:0];
      mul_op    = cmd.mul_hi ? emag_ff[MAG_W-1 -: HALF_W] : emag_ff[HALF_W-1:0];
      pp_in     = PP_W'(dmag_ff) * PP_W'(mul_op);
      prod_full = SUM_W'(pp_lo_ff) + (SUM_W'(pp_hi_ff) << HALF_W);
      sum_in    = {1'b0, m2_ff} + {1'b0, prod_ff};
      few_samples = (count_ff[COUNT_BITS-1:1] == '0);
   end

   // divider operands: delta magnitude by count, or M2 by count - 1
   always_comb begin
      if (cmd.div_report) begin
         div_dividend = m2_ff;
         div_divisor  = count_ff - COUNT_BITS'(1);
         div_steps    = STEP_W'(SUM_W);
      end else begin
         div_dividend = {dmag_ff, {(SUM_W - MAG_W){1'b0}}};
         div_divisor  = count_ff;
         div_steps    = STEP_W'(MAG_W);
      end
   end

   rmv_div #(
      .DIVISOR_W (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .done     (div_done),
      .quotient (quotient)
   );

   rmv_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (quotient << FRAC_BITS),
      .done     (sqrt_done),
      .root     (root)
   );

   // running statistics
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         mean_ff  <= '0;
         m2_ff    <= '0;
         sat_ff   <= 1'b0;
      end else begin
         if (cmd.delta) begin
            if (&count_ff) begin
               sat_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + COUNT_BITS'(1);
            end
         end
         if (cmd.mean_upd) begin
            mean_ff <= dneg_ff ? mean_ff - $signed(step_q) : mean_ff + $signed(step_q);
         end
         if (cmd.acc) begin
            if (sum_in[SUM_W]) begin
               m2_ff  <= '1;
               sat_ff <= 1'b1;
            end else begin
               m2_ff <= sum_in[SUM_W-1:0];
            end
         end
      end
   end

   // working registers of one update
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= x_in;
      end
      if (cmd.delta) begin
         dneg_ff <= delta_in[MEAN_W];
         dmag_ff <= delta_in[MEAN_W] ? MAG_W'(-delta_in) : MAG_W'(delta_in);
      end
      if (cmd.err) begin
         emag_ff <= e_in[MEAN_W] ? MAG_W'(-e_in) : MAG_W'(e_in);
      end
      if (cmd.mul_lo) begin
         pp_lo_ff <= pp_in;
      end
      if (cmd.mul_hi) begin
         pp_hi_ff <= pp_in;
      end
      if (cmd.prod) begin
         prod_ff <= prod_full >> FRAC_BITS;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_mean_ff      <= mean_ff;
         rsp_count_ff     <= CNT_OUT_W'(count_ff);
         rsp_valid_res_ff <= !few_samples;
         rsp_sat_ff       <= sat_ff;
         unique case (cmd.dev_sel)
            DEV_ONES: rsp_std_ff <= '1;
            DEV_ROOT: rsp_std_ff <= STD_W'(root);
            default:  rsp_std_ff <= '0;
         endcase
      end
   end

   assign status.div_done     = div_done;
   assign status.sqrt_done    = sqrt_done;
   assign status.few_samples  = few_samples;
   assign status.dev_overflow = |quotient[SUM_W-1 -: FRAC_BITS];

   assign rsp_mean         = rsp_mean_ff;
   assign rsp_std_dev      = rsp_std_ff;
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_valid_res    = rsp_valid_res_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

FILE: hdl/rmv_ctrl.sv
module rmv_ctrl
   import rmv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [KIND_W-1:0] req_kind,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  status_type        status,
   output cmd_type           cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_DELTA,
      S_DIV_GO,
      S_DIV_WAIT,
      S_MEAN,
      S_ERR,
      S_MUL_LO,
      S_MUL_HI,
      S_PROD,
      S_ACC,
      S_REPORT,
      S_REP_WAIT,
      S_REP_CHECK,
      S_SQRT_WAIT,
      S_RSP
   } state_type;

   state_type   state_ff, state_in;
   dev_sel_type dev_sel_ff, dev_sel_in;
   logic        req_ready_ff;
   logic        rsp_valid_ff;
   logic        accept;
   logic        rsp_free;

   assign accept   = req_valid && req_ready_ff;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      dev_sel_in = dev_sel_ff;
      cmd        = '0;
      cmd.dev_sel = dev_sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = accept;
            if (accept) begin
               priority if (req_kind == KIND_ADD) begin
                  state_in = S_DELTA;
               end else if (req_kind == KIND_CLEAR) begin
                  state_in = S_CLEAR;
               end else if (req_kind == KIND_REPORT) begin
                  state_in = S_REPORT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = S_IDLE;
         end
         S_DELTA: begin
            cmd.delta = 1'b1;
            state_in  = S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = S_MEAN;
            end
         end
         S_MEAN: begin
            cmd.mean_upd = 1'b1;
            state_in     = S_ERR;
         end
         S_ERR: begin
            cmd.err  = 1'b1;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_PROD;
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = S_IDLE;
         end
         S_REPORT: begin
            if (status.few_samples) begin
               dev_sel_in = DEV_ZERO;
               state_in   = S_RSP;
            end else begin
               cmd.div_start  = 1'b1;
               cmd.div_report = 1'b1;
               state_in       = S_REP_WAIT;
            end
         end
         S_REP_WAIT: begin
            if (status.div_done) begin
               state_in = S_REP_CHECK;
            end
         end
         S_REP_CHECK: begin
            if (status.dev_overflow) begin
               dev_sel_in = DEV_ONES;
               state_in   = S_RSP;
            end else begin
               cmd.sqrt_start = 1'b1;
               state_in       = S_SQRT_WAIT;
            end
         end
         S_SQRT_WAIT: begin
            if (status.sqrt_done) begin
               dev_sel_in = DEV_ROOT;
               state_in   = S_RSP;
            end
         end
         S_RSP: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dev_sel_ff   <= DEV_ZERO;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dev_sel_ff   <= dev_sel_in;
         req_ready_ff <= (state_in == S_IDLE);
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/running_mean_variance.sv
// Channel   Direction  Handshake            Payload
// request   in         req_valid/req_ready  req_kind, req_sample
// response  out        rsp_valid/rsp_ready  rsp_mean, rsp_std_dev, rsp_sample_count,
//                                           rsp_valid_res, rsp_saturated
//
// One request at a time. An add runs the 32-step divider for delta / count, then the
// multiply and accumulate steps. A report runs the 64-step divide of M2 / (n - 1), then
// the 32-step square root; it skips the root when the deviation clips, and skips both
// with fewer than two samples.
// Synchronous active-high reset clears all statistics; req_ready rises the cycle after.
// A waiting response holds in its output register while new add or clear requests run.
module running_mean_variance
   import rmv_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [MEAN_W-1:0]   rsp_mean,
   output logic [STD_W-1:0]           rsp_std_dev,
   output logic [CNT_OUT_W-1:0]       rsp_sample_count,
   output logic                       rsp_valid_res,
   output logic                       rsp_saturated
);

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequence each request: decode kind, step the divider, multiplier and square root
   rmv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hold count, mean, M2 and the flag; compute updates and the response
   rmv_datapath #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample       (req_sample),
      .rsp_mean         (rsp_mean),
      .rsp_std_dev      (rsp_std_dev),
      .rsp_sample_count (rsp_sample_count),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_saturated    (rsp_saturated)
   );

endmodule
